>>> hdl/ctr_pkg.sv
// ---------------------------------------------------------------------------
// ctr_pkg
// Shared constants for the colour temperature to linear sRGB converter:
// clamp limits, polynomial coefficients, matrix coefficients and widths.
// ---------------------------------------------------------------------------
package ctr_pkg;

    // Clamp limits of the input temperature in kelvin.
    localparam logic [15:0] T_MIN = 16'd1000;
    localparam logic [15:0] T_MAX = 16'd15000;
    localparam int          T_W   = 14;

    // Fraction bits of the chromaticity quotients.
    localparam int FRAC_Q = 30;

    // Width of the polynomial sums and of their quotients.
    localparam int POLY_W = 48;
    localparam int UV_W   = 30;

    // Lanes in the order u numerator, u denominator, v numerator, v denominator.
    // Constant terms at 2^40, linear terms at 2^40, square terms at 2^48.
    localparam logic [40:0] POLY_C0 [4] = '{
        41'd945709475070, 41'd1099511627776, 41'd348983589830, 41'd1099511627776
    };
    localparam logic [29:0] POLY_C1 [4] = '{
        30'd169454812, 30'd926250844, 30'd46488036, 30'd31857450
    };
    localparam logic [27:0] POLY_C2 [4] = '{
        28'd36209282, 28'd199325144, 28'd11835507, 28'd45445839
    };

    // XYZ to linear sRGB, signed Q20, rows red, green, blue.
    localparam int MAT_W = 23;
    localparam logic signed [MAT_W-1:0] XYZ_TO_RGB [3][3] = '{
        '{ 23'sd3397863, -23'sd1611807,  -23'sd522748},
        '{-23'sd1016349,  23'sd1967140,    23'sd43575},
        '{   23'sd58346,  -23'sd213937,  23'sd1108581}
    };

    // Signed tristimulus values at Q30.
    localparam int XYZ_W = 33;
    typedef logic signed [XYZ_W-1:0] t_xyz;

    // One output channel.
    typedef logic signed [15:0] t_level;

endpackage

>>> hdl/color_temperature_to_rgb.sv
// ---------------------------------------------------------------------------
// color_temperature_to_rgb
// Converts a blackbody colour temperature to linear sRGB in signed fixed
// point.
// ---------------------------------------------------------------------------
// Usage: raise start with a temperature on i_temperature_kelvin; the request
// is taken at any clock edge where start is high and busy is low. busy is
// never raised, so a new request may be issued in every cycle.
// The temperature is clamped to 1000..15000 K. Each request produces exactly
// one result: o_done is high for one cycle with o_red_level, o_green_level and
// o_blue_level, signed with OUT_FRAC_BITS fraction bits, saturated.
// A request passes through the polynomials, the u and v divider, a register
// that forms the X and Z numerators, the X and Z divider and the matrix and
// rounding stages. Throughput is one request per cycle; both dividers are
// fully pipelined, one quotient bit per stage.
// Results appear in request order. The receiver cannot hold results off, and
// none is needed: nothing inside waits on the output.
// A synchronous reset discards every request in flight; no result follows.
// ---------------------------------------------------------------------------
module color_temperature_to_rgb
    import ctr_pkg::*;
#(
    parameter int OUT_FRAC_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_temperature_kelvin,
    output logic        o_done,
    output t_level      o_red_level,
    output t_level      o_green_level,
    output t_level      o_blue_level
);

    localparam int XZ_Q   = 32;
    localparam int XZ_NW  = 34;
    localparam int XZ_DW  = 32;
    localparam int LAT    = 4 + UV_W + 1 + XZ_Q + 4;

    logic              w_poly_vld;
    logic [POLY_W-1:0] w_nu, w_du, w_nv, w_dv;
    logic              w_uv_vld;
    logic [UV_W-1:0]   w_u, w_v;
    logic              w_xz_vld;
    logic [XZ_Q-1:0]   w_xq, w_zq;
    logic signed [XZ_NW-1:0] w_w;

    logic              r_prep_vld;
    logic [XZ_NW-1:0]  r_xnum;
    logic [XZ_NW-1:0]  r_znum;
    logic [XZ_DW-1:0]  r_den;
    logic [XZ_Q:0]     r_neg_line;
    t_xyz              w_x, w_z;

    // Requests are never refused.
    assign busy = 1'b0;

    ctr_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_t     (i_temperature_kelvin),
        .o_valid (w_poly_vld),
        .o_nu    (w_nu),
        .o_du    (w_du),
        .o_nv    (w_nv),
        .o_dv    (w_dv)
    );

    ctr_div #(
        .NUM_W (POLY_W),
        .DEN_W (POLY_W),
        .Q_W   (UV_W)
    ) u_div_uv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_poly_vld),
        .i_num_a (w_nu),
        .i_den_a (w_du),
        .i_num_b (w_nv),
        .i_den_b (w_dv),
        .o_valid (w_uv_vld),
        .o_quo_a (w_u),
        .o_quo_b (w_v)
    );

    // Blue-side numerator 4 - u - 10v, which may dip below zero.
    assign w_w = (XZ_NW'(4) <<< FRAC_Q) - XZ_NW'(w_u)
                 - (XZ_NW'(w_v) <<< 3) - (XZ_NW'(w_v) <<< 1);

    // Register the X and Z numerators and the shared denominator 2v.
    always_ff @(posedge i_clk) begin
        r_xnum     <= XZ_NW'(w_u) + (XZ_NW'(w_u) << 1);
        r_znum     <= w_w[XZ_NW-1] ? XZ_NW'(-w_w) : XZ_NW'(w_w);
        r_den      <= {1'b0, w_v, 1'b0};
        r_neg_line <= {r_neg_line[XZ_Q-1:0], w_w[XZ_NW-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep_vld <= 1'b0;
        end else begin
            r_prep_vld <= w_uv_vld;
        end
    end

    ctr_div #(
        .NUM_W (XZ_NW),
        .DEN_W (XZ_DW),
        .Q_W   (XZ_Q)
    ) u_div_xz (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_prep_vld),
        .i_num_a (r_xnum),
        .i_den_a (r_den),
        .i_num_b (r_znum),
        .i_den_b (r_den),
        .o_valid (w_xz_vld),
        .o_quo_a (w_xq),
        .o_quo_b (w_zq)
    );

    // Restore the sign of Z; the sign line is aligned with the divider.
    assign w_x = t_xyz'({1'b0, w_xq});
    assign w_z = r_neg_line[XZ_Q] ? -t_xyz'({1'b0, w_zq}) : t_xyz'({1'b0, w_zq});

    ctr_mat #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_mat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_xz_vld),
        .i_x     (w_x),
        .i_z     (w_z),
        .o_valid (o_done),
        .o_red   (o_red_level),
        .o_green (o_green_level),
        .o_blue  (o_blue_level)
    );

`ifndef SYNTHESIS
    // Every request yields its result after the fixed latency.
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LAT o_done)
        else $error("result missing after request");

    // No result appears without a request the full latency earlier.
    a_no_spurious : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LAT))
        else $error("result without request");

    // The second divider takes over every item of the first.
    a_xz_follows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_uv_vld |-> ##(XZ_Q + 1) w_xz_vld)
        else $error("item lost between dividers");

    // v is strictly positive over the clamped range, so 2v never divides by zero.
    a_v_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_uv_vld |-> w_v != '0)
        else $error("zero denominator for X and Z");
`endif

endmodule

>>> hdl/ctr_poly.sv
// ---------------------------------------------------------------------------
// ctr_poly
// Clamps the temperature and evaluates the four quadratic polynomials of the
// u and v rational approximations over four register stages.
// ---------------------------------------------------------------------------
module ctr_poly
    import ctr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [15:0]       i_t,
    output logic              o_valid,
    output logic [POLY_W-1:0] o_nu,
    output logic [POLY_W-1:0] o_du,
    output logic [POLY_W-1:0] o_nv,
    output logic [POLY_W-1:0] o_dv
);

    logic [T_W-1:0]    r_t;
    logic [2*T_W-1:0]  r_t2;
    logic [43:0]       r_lin  [4];
    logic [43:0]       r_lin2 [4];
    logic [55:0]       r_sq   [4];
    logic [POLY_W-1:0] r_sum  [4];
    logic [3:0]        r_vld;
    logic [T_W-1:0]    w_clamp;

    // Clamp the request to the supported range.
    always_comb begin
        if (i_t < T_MIN) begin
            w_clamp = T_W'(T_MIN);
        end else if (i_t > T_MAX) begin
            w_clamp = T_W'(T_MAX);
        end else begin
            w_clamp = i_t[T_W-1:0];
        end
    end

    // Valid bits travel alongside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    // Square and linear products, then square terms, then the sums.
    always_ff @(posedge i_clk) begin
        r_t  <= w_clamp;
        r_t2 <= r_t * r_t;
        for (int l = 0; l < 4; l++) begin
            r_lin[l]  <= 44'(POLY_C1[l]) * 44'(r_t);
            r_lin2[l] <= r_lin[l];
            r_sq[l]   <= 56'(POLY_C2[l]) * 56'(r_t2);
            r_sum[l]  <= POLY_W'(48'(POLY_C0[l]) + 48'(r_lin2[l])
                         + 48'((57'(r_sq[l]) + 57'd128) >> 8));
        end
    end

    assign o_valid = r_vld[3];
    assign o_nu    = r_sum[0];
    assign o_du    = r_sum[1];
    assign o_nv    = r_sum[2];
    assign o_dv    = r_sum[3];

endmodule

>>> hdl/ctr_div.sv
// ---------------------------------------------------------------------------
// ctr_div
// Two-lane pipelined restoring divider giving floor(num * 2^30 / den), one
// quotient bit per register stage. The quotient must fit in Q_W bits.
// ---------------------------------------------------------------------------
module ctr_div
    import ctr_pkg::*;
#(
    parameter int NUM_W = 48,
    parameter int DEN_W = 48,
    parameter int Q_W   = 30
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num_a,
    input  logic [DEN_W-1:0] i_den_a,
    input  logic [NUM_W-1:0] i_num_b,
    input  logic [DEN_W-1:0] i_den_b,
    output logic             o_valid,
    output logic [Q_W-1:0]   o_quo_a,
    output logic [Q_W-1:0]   o_quo_b
);

    localparam int N_W = NUM_W + FRAC_Q;

    logic [N_W-1:0]   w_ext  [2];
    logic [DEN_W-1:0] w_rem0 [2];
    logic [Q_W-1:0]   w_low0 [2];
    logic [DEN_W-1:0] w_den0 [2];

    logic [DEN_W-1:0] r_rem [Q_W][2];
    logic [Q_W-1:0]   r_low [Q_W][2];
    logic [DEN_W-1:0] r_den [Q_W][2];
    logic [Q_W-1:0]   r_vld;

    logic [DEN_W-1:0] n_rem [Q_W][2];
    logic [Q_W-1:0]   n_low [Q_W][2];
    logic [DEN_W-1:0] n_den [Q_W][2];

    // Scale the numerators; the upper part starts as the partial remainder.
    always_comb begin
        w_ext[0]  = {i_num_a, FRAC_Q'(0)};
        w_ext[1]  = {i_num_b, FRAC_Q'(0)};
        w_den0[0] = i_den_a;
        w_den0[1] = i_den_b;
        for (int l = 0; l < 2; l++) begin
            w_rem0[l] = DEN_W'(w_ext[l] >> Q_W);
            w_low0[l] = w_ext[l][Q_W-1:0];
        end
    end

    // One trial subtraction per stage; quotient bits shift in at the bottom.
    always_comb begin
        logic [DEN_W-1:0] rem;
        logic [Q_W-1:0]   low;
        logic [DEN_W-1:0] den;
        logic [DEN_W:0]   trial;
        for (int s = 0; s < Q_W; s++) begin
            for (int l = 0; l < 2; l++) begin
                if (s == 0) begin
                    rem = w_rem0[l];
                    low = w_low0[l];
                    den = w_den0[l];
                end else begin
                    rem = r_rem[s-1][l];
                    low = r_low[s-1][l];
                    den = r_den[s-1][l];
                end
                trial = {rem, low[Q_W-1]};
                if (trial >= {1'b0, den}) begin
                    n_rem[s][l] = DEN_W'(trial - {1'b0, den});
                    n_low[s][l] = {low[Q_W-2:0], 1'b1};
                end else begin
                    n_rem[s][l] = trial[DEN_W-1:0];
                    n_low[s][l] = {low[Q_W-2:0], 1'b0};
                end
                n_den[s][l] = den;
            end
        end
    end

    // Stage registers.
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_low <= n_low;
        r_den <= n_den;
    end

    // Valid bits for each stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[Q_W-2:0], i_valid};
        end
    end

    assign o_valid = r_vld[Q_W-1];
    assign o_quo_a = r_low[Q_W-1][0];
    assign o_quo_b = r_low[Q_W-1][1];

endmodule

>>> hdl/ctr_mat.sv
// ---------------------------------------------------------------------------
// ctr_mat
// Applies the XYZ to linear sRGB matrix with Y fixed at one, then rounds
// each channel half away from zero and saturates it to 16 bits.
// ---------------------------------------------------------------------------
module ctr_mat
    import ctr_pkg::*;
#(
    parameter int OUT_FRAC_BITS = 12
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_xyz   i_x,
    input  t_xyz   i_z,
    output logic   o_valid,
    output t_level o_red,
    output t_level o_green,
    output t_level o_blue
);

    localparam int PROD_W = MAT_W + XYZ_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int SH     = 2 * FRAC_Q - 10 - OUT_FRAC_BITS;
    localparam logic [ACC_W:0] HALF = (ACC_W + 1)'(1) << (SH - 1);
    localparam t_xyz Y_ONE = t_xyz'(1) <<< FRAC_Q;

    t_xyz                      w_xyz [3];
    logic signed [PROD_W-1:0]  r_prod [3][3];
    logic signed [ACC_W-1:0]   r_acc [3];
    logic [ACC_W-1:0]          r_mag [3];
    logic [2:0]                r_neg;
    t_level                    r_out [3];
    logic [3:0]                r_vld;
    logic [ACC_W:0]            w_rnd [3];
    t_level                    n_out [3];

    assign w_xyz[0] = i_x;
    assign w_xyz[1] = Y_ONE;
    assign w_xyz[2] = i_z;

    // Products, three-term sums, magnitude and sign, then the rounded outputs.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                r_prod[k][j] <= XYZ_TO_RGB[k][j] * w_xyz[j];
            end
            r_acc[k] <= ACC_W'(r_prod[k][0]) + ACC_W'(r_prod[k][1])
                        + ACC_W'(r_prod[k][2]);
            r_neg[k] <= r_acc[k][ACC_W-1];
            r_mag[k] <= r_acc[k][ACC_W-1] ? ACC_W'(-r_acc[k]) : ACC_W'(r_acc[k]);
            r_out[k] <= n_out[k];
        end
    end

    // Round the magnitude, shift down and saturate.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_rnd[k] = ({1'b0, r_mag[k]} + HALF) >> SH;
            if (r_neg[k]) begin
                if (w_rnd[k] > (ACC_W + 1)'(32768)) begin
                    n_out[k] = 16'sh8000;
                end else begin
                    n_out[k] = t_level'((~w_rnd[k]) + 1'b1);
                end
            end else begin
                if (w_rnd[k] > (ACC_W + 1)'(32767)) begin
                    n_out[k] = 16'sh7FFF;
                end else begin
                    n_out[k] = t_level'(w_rnd[k]);
                end
            end
        end
    end

    // Valid bits alongside the four stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    assign o_valid = r_vld[3];
    assign o_red   = r_out[0];
    assign o_green = r_out[1];
    assign o_blue  = r_out[2];

endmodule
